// ===== rtl/hybrid_branch_predictor_assert.svh =====
// assertion macros for the hybrid branch predictor
// expects clk and rst_n in the scope of the use
`ifndef HYBRID_BRANCH_PREDICTOR_ASSERT_SVH
`define HYBRID_BRANCH_PREDICTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HBP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hbp_pkg.sv =====
// shared types, constants and helpers of the hybrid branch predictor
// no dependencies
package hbp_pkg;

  // default table and history sizes
  localparam int BIMODAL_INDEX_BITS_DEF = 10;
  localparam int GSHARE_INDEX_BITS_DEF  = 10;
  localparam int HISTORY_BITS_DEF       = 6;
  localparam int CHOOSER_INDEX_BITS_DEF = 10;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_PREDICTOR_MODE = 3'h0;

  // predictor mode codes
  localparam logic [1:0] MODE_BIMODAL = 2'd0;
  localparam logic [1:0] MODE_GSHARE  = 2'd1;
  localparam logic [1:0] MODE_HYBRID  = 2'd2;

  // counter reset values and saturation limits
  localparam logic [1:0] CTR_WEAK_TAKEN   = 2'd2;
  localparam logic [1:0] CHS_WEAK_BIMODAL = 2'd1;
  localparam logic [1:0] CTR_MAX          = 2'd3;
  localparam logic [1:0] CTR_MIN          = 2'd0;

  typedef struct packed {
    logic [31:0] pc;
    logic        taken;
  } in_beat_t;

  typedef struct packed {
    logic        predicted_taken;
    logic        mispredicted;
    logic        chose_gshare;
    logic [31:0] branch_total;
    logic [31:0] miss_total;
  } out_beat_t;

  // outcome of one branch: prediction and table updates
  typedef struct packed {
    logic       pred;
    logic       miss;
    logic       use_g;
    logic       bim_we;
    logic       gsh_we;
    logic       chs_we;
    logic [1:0] bim_val;
    logic [1:0] gsh_val;
    logic [1:0] chs_val;
  } decide_t;

  // 2-bit saturating counter step
  function automatic logic [1:0] sat_train(input logic [1:0] c, input logic up);
    logic [1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/hbp_cfg_regs.sv =====
// apb-style register block holding the predictor mode
// depends on hbp_pkg
module hbp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hbp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [1:0]                     mode
);

  logic [1:0] mode_r;
  logic       sel_mode;
  logic       wr_fire;

  // word decode, byte lanes ignored
  assign sel_mode = (paddr[hbp_pkg::CFG_ADDR_W-1:2] ==
                     hbp_pkg::ADDR_PREDICTOR_MODE[hbp_pkg::CFG_ADDR_W-1:2]);
  assign wr_fire  = psel && penable && pwrite;
  assign pready   = 1'b1;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= hbp_pkg::MODE_HYBRID;
    end else if (wr_fire && sel_mode) begin
      mode_r <= pwdata[1:0];
    end
  end

  // read mux
  assign prdata = sel_mode ? {30'd0, mode_r} : 32'd0;
  assign mode   = mode_r;

endmodule

// ===== rtl/hbp_ctr_table.sv =====
// table of 2-bit counters with registered read and last-write bypass
// depends on hbp_pkg (for reset value constants at the instance)
module hbp_ctr_table #(
  parameter int         IDX_BITS  = hbp_pkg::BIMODAL_INDEX_BITS_DEF,
  parameter logic [1:0] RESET_VAL = hbp_pkg::CTR_WEAK_TAKEN
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr_en,
  input  logic [IDX_BITS-1:0] clr_idx,
  input  logic                rd_en,
  input  logic [IDX_BITS-1:0] rd_idx,
  input  logic                wr_en,
  input  logic [1:0]          wr_val,
  output logic [1:0]          rd_val
);

  localparam int DEPTH = 1 << IDX_BITS;

  logic [1:0]          mem_r [DEPTH];
  logic [1:0]          rd_q_r;
  logic [IDX_BITS-1:0] rd_idx_r;
  logic                lw_valid_r;
  logic [IDX_BITS-1:0] lw_idx_r;
  logic [1:0]          lw_val_r;

  // storage: clearing sweep or write-back to the held index, registered read
  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem_r[clr_idx] <= RESET_VAL;
    end else if (wr_en) begin
      mem_r[rd_idx_r] <= wr_val;
    end
    if (rd_en) begin
      rd_q_r   <= mem_r[rd_idx];
      rd_idx_r <= rd_idx;
    end
  end

  // last write, covers a read issued on the edge of that write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (wr_en) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_idx_r <= rd_idx_r;
      lw_val_r <= wr_val;
    end
  end

  assign rd_val = (lw_valid_r && (lw_idx_r == rd_idx_r)) ? lw_val_r : rd_q_r;

endmodule

// ===== rtl/hbp_decide.sv =====
// prediction choice and counter training for one branch
// depends on hbp_pkg
module hbp_decide (
  input  logic             [1:0] mode,
  input  logic                   taken,
  input  logic             [1:0] bim_ctr,
  input  logic             [1:0] gsh_ctr,
  input  logic             [1:0] chs_ctr,
  output hbp_pkg::decide_t       dec
);

  logic bp;
  logic gp;
  logic use_g;
  logic hybrid;

  assign bp = bim_ctr[1];
  assign gp = gsh_ctr[1];

  // component selection, the unused code behaves as hybrid
  always_comb begin
    unique case (mode)
      hbp_pkg::MODE_BIMODAL: begin
        use_g  = 1'b0;
        hybrid = 1'b0;
      end
      hbp_pkg::MODE_GSHARE: begin
        use_g  = 1'b1;
        hybrid = 1'b0;
      end
      default: begin
        use_g  = chs_ctr[1];
        hybrid = 1'b1;
      end
    endcase
  end

  // prediction and updates
  always_comb begin
    dec.use_g   = use_g;
    dec.pred    = use_g ? gp : bp;
    dec.miss    = dec.pred != taken;
    dec.bim_we  = !use_g;
    dec.gsh_we  = use_g;
    dec.bim_val = hbp_pkg::sat_train(bim_ctr, taken);
    dec.gsh_val = hbp_pkg::sat_train(gsh_ctr, taken);
    // chooser moves only when exactly one component was right
    dec.chs_we  = hybrid && (bp != gp);
    dec.chs_val = hbp_pkg::sat_train(chs_ctr, gp == taken);
  end

endmodule

// ===== rtl/hybrid_branch_predictor.sv =====
// top level of the tournament branch predictor (bimodal, gshare, chooser)
// depends on hbp_pkg, hbp_cfg_regs, hbp_ctr_table, hbp_decide
//
//   channel | signals                      | beat
//   in      | in_valid, in_ready, in_beat  | pc, taken
//   out     | out_valid, out_ready, out_beat | prediction, miss, source, totals
//   cfg     | psel..pready                 | predictor_mode at byte address 0
//
// one branch per cycle while out_ready keeps up: tables are read on the accept
// edge, prediction and write-back happen in the table stage and the result lands
// in the output register, which raises out_valid.
// after reset a clearing pass writes every table entry; no branch is taken
// meanwhile, configuration writes are.
// a stalled output holds one branch in the table stage; in_ready then drops.
`include "hybrid_branch_predictor_assert.svh"

module hybrid_branch_predictor #(
  parameter int BIMODAL_INDEX_BITS = hbp_pkg::BIMODAL_INDEX_BITS_DEF,
  parameter int GSHARE_INDEX_BITS  = hbp_pkg::GSHARE_INDEX_BITS_DEF,
  parameter int HISTORY_BITS       = hbp_pkg::HISTORY_BITS_DEF,
  parameter int CHOOSER_INDEX_BITS = hbp_pkg::CHOOSER_INDEX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hbp_pkg::in_beat_t              in_beat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output hbp_pkg::out_beat_t             out_beat,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hbp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int BG_MAX = (BIMODAL_INDEX_BITS > GSHARE_INDEX_BITS) ?
                          BIMODAL_INDEX_BITS : GSHARE_INDEX_BITS;
  localparam int CLR_BITS = (BG_MAX > CHOOSER_INDEX_BITS) ? BG_MAX : CHOOSER_INDEX_BITS;

  logic [1:0]                    mode;
  logic                          clr_busy_r;
  logic [CLR_BITS-1:0]           clr_cnt_r;
  logic [HISTORY_BITS-1:0]       history_r;
  logic [HISTORY_BITS-1:0]       history_nxt;
  logic [GSHARE_INDEX_BITS-1:0]  hist_aligned;
  logic [BIMODAL_INDEX_BITS-1:0] bim_idx;
  logic [GSHARE_INDEX_BITS-1:0]  gsh_idx;
  logic [CHOOSER_INDEX_BITS-1:0] chs_idx;
  logic                          in_fire;
  logic                          s1_fire;
  logic                          s1_valid_r;
  logic                          s1_taken_r;
  logic [1:0]                    bim_ctr;
  logic [1:0]                    gsh_ctr;
  logic [1:0]                    chs_ctr;
  hbp_pkg::decide_t              dec;
  logic                          out_valid_r;
  hbp_pkg::out_beat_t            out_beat_r;
  logic [31:0]                   branch_cnt_r;
  logic [31:0]                   miss_cnt_r;
  logic [31:0]                   branch_cnt_nxt;
  logic [31:0]                   miss_cnt_nxt;

  // configuration registers
  hbp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode)
  );

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + CLR_BITS'(1);
      if (&clr_cnt_r) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // handshake
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!s1_valid_r || s1_fire);
  assign in_fire  = in_valid && in_ready;

  // history aligned to the top of the gshare index
  if (GSHARE_INDEX_BITS > HISTORY_BITS) begin : g_hist_narrow
    assign hist_aligned = {history_r, (GSHARE_INDEX_BITS - HISTORY_BITS)'(0)};
  end else if (GSHARE_INDEX_BITS == HISTORY_BITS) begin : g_hist_equal
    assign hist_aligned = history_r;
  end else begin : g_hist_wide
    assign hist_aligned = history_r[GSHARE_INDEX_BITS-1:0];
  end

  // history shifts right, outcome enters at the top
  if (HISTORY_BITS == 1) begin : g_shift_one
    assign history_nxt = in_beat.taken;
  end else begin : g_shift_many
    assign history_nxt = {in_beat.taken, history_r[HISTORY_BITS-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      history_r <= '0;
    end else if (in_fire) begin
      history_r <= history_nxt;
    end
  end

  // table indices from the incoming beat
  assign bim_idx = in_beat.pc[BIMODAL_INDEX_BITS+1:2];
  assign gsh_idx = in_beat.pc[GSHARE_INDEX_BITS+1:2] ^ hist_aligned;
  assign chs_idx = in_beat.pc[CHOOSER_INDEX_BITS+1:2];

  // counter tables
  hbp_ctr_table #(
    .IDX_BITS  (BIMODAL_INDEX_BITS),
    .RESET_VAL (hbp_pkg::CTR_WEAK_TAKEN)
  ) u_bim (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr_en  (clr_busy_r),
    .clr_idx (clr_cnt_r[BIMODAL_INDEX_BITS-1:0]),
    .rd_en   (in_fire),
    .rd_idx  (bim_idx),
    .wr_en   (s1_fire && dec.bim_we),
    .wr_val  (dec.bim_val),
    .rd_val  (bim_ctr)
  );

  hbp_ctr_table #(
    .IDX_BITS  (GSHARE_INDEX_BITS),
    .RESET_VAL (hbp_pkg::CTR_WEAK_TAKEN)
  ) u_gsh (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr_en  (clr_busy_r),
    .clr_idx (clr_cnt_r[GSHARE_INDEX_BITS-1:0]),
    .rd_en   (in_fire),
    .rd_idx  (gsh_idx),
    .wr_en   (s1_fire && dec.gsh_we),
    .wr_val  (dec.gsh_val),
    .rd_val  (gsh_ctr)
  );

  hbp_ctr_table #(
    .IDX_BITS  (CHOOSER_INDEX_BITS),
    .RESET_VAL (hbp_pkg::CHS_WEAK_BIMODAL)
  ) u_chs (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr_en  (clr_busy_r),
    .clr_idx (clr_cnt_r[CHOOSER_INDEX_BITS-1:0]),
    .rd_en   (in_fire),
    .rd_idx  (chs_idx),
    .wr_en   (s1_fire && dec.chs_we),
    .wr_val  (dec.chs_val),
    .rd_val  (chs_ctr)
  );

  // table stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_taken_r <= in_beat.taken;
    end
  end

  hbp_decide u_decide (
    .mode    (mode),
    .taken   (s1_taken_r),
    .bim_ctr (bim_ctr),
    .gsh_ctr (gsh_ctr),
    .chs_ctr (chs_ctr),
    .dec     (dec)
  );

  // running totals
  assign branch_cnt_nxt = branch_cnt_r + 32'd1;
  assign miss_cnt_nxt   = miss_cnt_r + {31'd0, dec.miss};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      branch_cnt_r <= '0;
      miss_cnt_r   <= '0;
    end else if (s1_fire) begin
      branch_cnt_r <= branch_cnt_nxt;
      miss_cnt_r   <= miss_cnt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_beat_r.predicted_taken <= dec.pred;
      out_beat_r.mispredicted    <= dec.miss;
      out_beat_r.chose_gshare    <= dec.use_g;
      out_beat_r.branch_total    <= branch_cnt_nxt;
      out_beat_r.miss_total      <= miss_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // checks
  `HBP_ASSERT_SAME(a_no_accept_in_clear, clr_busy_r, !in_ready, "branch accepted during clear")
  `HBP_ASSERT_NEXT(a_accept_fills_stage, in_fire, s1_valid_r, "accepted beat lost")
  `HBP_ASSERT_NEXT(a_total_steps, s1_fire, branch_cnt_r == $past(branch_cnt_r) + 32'd1,
                   "branch total did not step")

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the hybrid branch predictor top level
// mirrors the bimodal, gshare and chooser tables and compares every result beat
// depends on hbp_pkg and the rtl of hybrid_branch_predictor
`timescale 1ns / 100ps

module tb;
  import hbp_pkg::*;

  // mode code outside the documented range, behaves as hybrid
  localparam logic [1:0] MODE_HYBRID_ALT = 2'd3;
  localparam int HOT_COUNT = 16;
  localparam int DIRECTED_COUNT = 23;
  localparam int PHASE_COUNT = 6;
  localparam int PHASE_BRANCHES = 238;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_HOLD} rx_style_t;

  // mirror of the predictor tables, history and totals
  class outcome_scoreboard;
    localparam int BIM_DEPTH = 1 << BIMODAL_INDEX_BITS_DEF;
    localparam int GSH_DEPTH = 1 << GSHARE_INDEX_BITS_DEF;
    localparam int CHS_DEPTH = 1 << CHOOSER_INDEX_BITS_DEF;

    logic [1:0] bim_ctr [BIM_DEPTH];
    logic [1:0] gsh_ctr [GSH_DEPTH];
    logic [1:0] chs_ctr [CHS_DEPTH];
    logic [HISTORY_BITS_DEF-1:0] history;
    logic [31:0] branches;
    logic [31:0] misses;
    logic [1:0] mode;
    out_beat_t pending [$];
    int unsigned errors;

    function new();
      foreach (bim_ctr[i]) bim_ctr[i] = CTR_WEAK_TAKEN;
      foreach (gsh_ctr[i]) gsh_ctr[i] = CTR_WEAK_TAKEN;
      foreach (chs_ctr[i]) chs_ctr[i] = CHS_WEAK_BIMODAL;
      history = '0;
      branches = '0;
      misses = '0;
      mode = MODE_HYBRID;
      errors = 0;
    endfunction

    function void set_mode(logic [1:0] m);
      mode = m;
    endfunction

    function bit drained();
      return pending.size() == 0;
    endfunction

    // saturating two-bit step
    function logic [1:0] nudge(logic [1:0] c, logic up);
      if (up) return (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
      return (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    endfunction

    // work out the result of one accepted branch and train the tables
    function void note_branch(in_beat_t b);
      int unsigned word, bi, gi, ci, sh;
      logic bim_pred, gsh_pred, use_gsh, pred;
      out_beat_t want;
      word = b.pc >> 2;
      bi = word % BIM_DEPTH;
      ci = word % CHS_DEPTH;
      sh = (GSHARE_INDEX_BITS_DEF > HISTORY_BITS_DEF) ?
           GSHARE_INDEX_BITS_DEF - HISTORY_BITS_DEF : 0;
      gi = ((word % GSH_DEPTH) ^ (int'(history) << sh)) % GSH_DEPTH;
      bim_pred = bim_ctr[bi][1];
      gsh_pred = gsh_ctr[gi][1];
      if (mode == MODE_BIMODAL) use_gsh = 1'b0;
      else if (mode == MODE_GSHARE) use_gsh = 1'b1;
      else use_gsh = chs_ctr[ci][1];
      pred = use_gsh ? gsh_pred : bim_pred;
      // only the component that made the call trains
      if (use_gsh) gsh_ctr[gi] = nudge(gsh_ctr[gi], b.taken);
      else bim_ctr[bi] = nudge(bim_ctr[bi], b.taken);
      // chooser leans toward whichever one alone was right
      if (mode == MODE_HYBRID || mode == MODE_HYBRID_ALT) begin
        if (bim_pred == b.taken && gsh_pred != b.taken) begin
          chs_ctr[ci] = nudge(chs_ctr[ci], 1'b0);
        end else if (gsh_pred == b.taken && bim_pred != b.taken) begin
          chs_ctr[ci] = nudge(chs_ctr[ci], 1'b1);
        end
      end
      history = {b.taken, history[HISTORY_BITS_DEF-1:1]};
      branches = branches + 32'd1;
      if (pred != b.taken) misses = misses + 32'd1;
      want.predicted_taken = pred;
      want.mispredicted = (pred != b.taken);
      want.chose_gshare = use_gsh;
      want.branch_total = branches;
      want.miss_total = misses;
      pending.push_back(want);
    endfunction

    // compare a result beat with the oldest outstanding one
    function void check_outcome(out_beat_t got);
      out_beat_t want;
      if (pending.size() == 0) begin
        $error("result beat with nothing outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.predicted_taken !== want.predicted_taken) begin
        $error("predicted_taken: expected %0d, got %0d", want.predicted_taken,
               got.predicted_taken);
        errors++;
      end
      if (got.mispredicted !== want.mispredicted) begin
        $error("mispredicted: expected %0d, got %0d", want.mispredicted, got.mispredicted);
        errors++;
      end
      if (got.chose_gshare !== want.chose_gshare) begin
        $error("chose_gshare: expected %0d, got %0d", want.chose_gshare, got.chose_gshare);
        errors++;
      end
      if (got.branch_total !== want.branch_total) begin
        $error("branch_total: expected %0d, got %0d", want.branch_total, got.branch_total);
        errors++;
      end
      if (got.miss_total !== want.miss_total) begin
        $error("miss_total: expected %0d, got %0d", want.miss_total, got.miss_total);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_beat_t in_beat;
  logic out_valid;
  logic out_ready;
  out_beat_t out_beat;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  outcome_scoreboard book = new();
  int sent_branches = 0;
  bit held_off = 1'b0;

  // branch sites reused by the random part so that counters saturate
  logic [31:0] hot_pc [HOT_COUNT];
  int unsigned hot_bias [HOT_COUNT];
  int unsigned hot_period [HOT_COUNT];
  int unsigned hot_trip [HOT_COUNT];

  logic [31:0] dir_pc [DIRECTED_COUNT] = '{
    32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0003,
    32'h0000_1000, 32'h0000_1000, 32'h0000_1000, 32'h0000_1000,
    32'h0000_1000, 32'h0000_1000, 32'h0000_1000, 32'h0000_1000,
    32'hAAAA_AAAA, 32'h5555_5555,
    32'h0000_2004, 32'h0000_2004, 32'h0000_2004, 32'h0000_2004,
    32'h0000_2004, 32'h0000_2004,
    32'h8000_0000, 32'h7FFF_FFFC};
  logic dir_taken [DIRECTED_COUNT] = '{
    1, 0, 1, 0, 0,
    0, 0, 0, 0,
    1, 1, 1, 1,
    1, 0,
    1, 0, 1, 0, 1, 0,
    1, 0};
  logic [1:0] phase_modes [PHASE_COUNT] = '{
    MODE_BIMODAL, MODE_GSHARE, MODE_HYBRID_ALT, MODE_HYBRID, MODE_BIMODAL, MODE_HYBRID};

  hybrid_branch_predictor uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_beat (out_beat),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // offer one branch beat and hold it until taken
  task automatic send_branch(input in_beat_t b);
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat <= b;
    do @(posedge clk); while (!in_ready);
    book.note_branch(b);
    sent_branches++;
  endtask

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // write the mode register: setup then access
  task automatic write_mode(input logic [1:0] m);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_PREDICTOR_MODE;
    pwdata <= {30'd0, m};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_mode(m);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // let every outstanding result come out, then let the bench idle
  task automatic wait_drained();
    while (!book.drained()) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly hot sites with biased or looping outcomes, some fully random
  function automatic in_beat_t random_branch();
    in_beat_t b;
    int unsigned k;
    if ($urandom_range(0, 99) < 75) begin
      k = $urandom_range(0, HOT_COUNT - 1);
      b.pc = hot_pc[k] | 32'($urandom_range(0, 3));
      if (k < 6) begin
        b.taken = ($urandom_range(0, 99) < hot_bias[k]);
      end else if (k < 11) begin
        b.taken = (hot_trip[k] != hot_period[k] - 1);
        hot_trip[k] = (hot_trip[k] + 1) % hot_period[k];
      end else begin
        b.taken = 1'($urandom_range(0, 1));
      end
    end else begin
      b.pc = $urandom;
      b.taken = 1'($urandom_range(0, 1));
    end
    return b;
  endfunction

  // bursts of branches with random gaps
  task automatic run_phase(input int count);
    int done_cnt;
    int burst;
    int gap;
    done_cnt = 0;
    while (done_cnt < count) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && done_cnt < count; k++) begin
        send_branch(random_branch());
        done_cnt++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) idle_sender(gap);
    end
    idle_sender(1);
  endtask

  // result side: stretches of open, random, periodic and held-off ready
  initial begin
    int span;
    int pct;
    int period;
    rx_style_t style;
    out_ready = 1'b0;
    forever begin
      span = $urandom_range(10, 120);
      pct = $urandom_range(25, 85);
      period = $urandom_range(2, 5);
      case ($urandom_range(0, 7))
        0, 1, 2: style = RX_OPEN;
        3, 4, 5: style = RX_RANDOM;
        6: style = RX_PERIODIC;
        default: style = RX_HOLD;
      endcase
      if (!held_off && sent_branches > 100) begin
        // one long hold-off while branches keep coming
        style = RX_HOLD;
        span = 150;
        held_off = 1'b1;
      end else if (style == RX_HOLD) begin
        span = $urandom_range(20, 60);
      end
      for (int i = 0; i < span; i++) begin
        @(negedge clk);
        case (style)
          RX_OPEN: out_ready <= 1'b1;
          RX_RANDOM: out_ready <= ($urandom_range(0, 99) < pct);
          RX_PERIODIC: out_ready <= (i % period == 0);
          default: out_ready <= 1'b0;
        endcase
      end
    end
  end

  // result beats checked as they are accepted
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_outcome(out_beat);
  end

  // main sequence
  initial begin
    in_beat_t b;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int k = 0; k < HOT_COUNT; k++) begin
      // odd sites alias the bimodal and chooser entry of their neighbour
      hot_pc[k] = (k % 2 == 1) ? (hot_pc[k-1] ^ 32'h0001_0000) : ($urandom & ~32'h3);
      hot_bias[k] = (k % 2 == 1) ? 92 : 8;
      hot_period[k] = $urandom_range(2, 6);
      hot_trip[k] = 0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default mode written again while the tables clear
    write_mode(MODE_HYBRID);

    // directed branches: address extremes, ignored low bits, saturation,
    // chooser training on an alternating branch
    for (int k = 0; k < DIRECTED_COUNT; k++) begin
      b.pc = dir_pc[k];
      b.taken = dir_taken[k];
      send_branch(b);
    end
    idle_sender(1);
    wait_drained();

    // random phases, each under its own mode
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_mode(phase_modes[p]);
      run_phase(PHASE_BRANCHES);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (book.errors == 0 && book.drained()) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #6_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
